FILE: rtl/csvp_pkg.sv
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared types and character codes for the quoted CSV record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package csvp_pkg;

  // Width of the population field on the result channel
  localparam int unsigned POP_OUT_W = 31;

  // Characters the grammar looks for
  localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;  // '"'
  localparam logic [7:0] CHAR_LPAREN = 8'h28;  // '('

  // Decimal radix of the population accumulator
  localparam int unsigned RADIX = 10;

  // Parser position within the current line
  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_RANK   = 4'd1,
    ST_OPENQ  = 4'd2,
    ST_NAME   = 4'd3,
    ST_SEP    = 4'd4,
    ST_POPSEL = 4'd5,
    ST_POPNUM = 4'd6,
    ST_DONE   = 4'd7,
    ST_ERR    = 4'd8
  } parse_state_e;

  // Kind of a result transaction
  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } result_kind_e;

  // Result of one parse step, without the population
  typedef struct packed {
    logic         valid;
    result_kind_e kind;
    logic [7:0]   name_char;
  } step_res_t;

endpackage : csvp_pkg

`default_nettype wire

FILE: rtl/csvp_step.sv
// ----------------------------------------------------------------------------
// csvp_step
// One parse step: next state, next accumulator and the optional result for
// a single text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module csvp_step #(
  parameter int unsigned POP_BITS = 31
) (
  input  csvp_pkg::parse_state_e                  state_i,
  input  logic [POP_BITS-1:0]                     acc_i,
  input  logic [7:0]                              text_byte_i,
  input  logic                                    line_end_i,
  output csvp_pkg::parse_state_e                  state_o,
  output logic [POP_BITS-1:0]                     acc_o,
  output csvp_pkg::step_res_t                     res_o,
  output logic [csvp_pkg::POP_OUT_W-1:0]          population_o
);
  import csvp_pkg::*;

  localparam int unsigned  MacW   = POP_BITS + 4;
  localparam logic [POP_BITS-1:0] PopMax = '1;
  localparam int unsigned  ExtW   = (POP_BITS > POP_OUT_W) ? POP_BITS : POP_OUT_W;

  logic                is_digit;
  logic [3:0]          digit;
  logic [MacW-1:0]     mac_full;
  logic [POP_BITS-1:0] mac_sat;
  parse_state_e        next_state;
  logic [POP_BITS-1:0] next_acc;
  logic                name_out;
  logic                accepted;
  logic [POP_BITS-1:0] accept_pop;
  logic [ExtW-1:0]     pop_ext;

  // Decode the digit
  assign is_digit = (text_byte_i >= CHAR_ZERO) && (text_byte_i <= CHAR_NINE);
  assign digit    = 4'(text_byte_i - CHAR_ZERO);

  // Multiply by ten and add, saturating at the field maximum
  assign mac_full = (MacW'(acc_i) << 3) + (MacW'(acc_i) << 1) + MacW'(digit);
  assign mac_sat  = (mac_full > MacW'(PopMax)) ? PopMax : mac_full[POP_BITS-1:0];

  // Grammar transitions
  always_comb begin
    next_state = ST_ERR;
    next_acc   = acc_i;
    name_out   = 1'b0;
    accepted   = 1'b0;
    accept_pop = acc_i;
    unique case (state_i)
      ST_START: begin
        next_state = is_digit ? ST_RANK : ST_ERR;
      end
      ST_RANK: begin
        if (is_digit) begin
          next_state = ST_RANK;
        end else if (text_byte_i == CHAR_COMMA) begin
          next_state = ST_OPENQ;
        end
      end
      ST_OPENQ: begin
        next_state = (text_byte_i == CHAR_QUOTE) ? ST_NAME : ST_ERR;
      end
      ST_NAME: begin
        if (text_byte_i == CHAR_QUOTE) begin
          next_state = ST_SEP;
        end else begin
          next_state = ST_NAME;
          name_out   = 1'b1;
        end
      end
      ST_SEP: begin
        next_state = (text_byte_i == CHAR_COMMA) ? ST_POPSEL : ST_ERR;
      end
      ST_POPSEL: begin
        if (text_byte_i == CHAR_QUOTE) begin
          next_state = ST_POPNUM;
          next_acc   = '0;
        end else if (text_byte_i == CHAR_LPAREN) begin
          next_state = ST_DONE;
          next_acc   = '0;
          accepted   = 1'b1;
          accept_pop = '0;
        end
      end
      ST_POPNUM: begin
        if (is_digit) begin
          next_state = ST_POPNUM;
          next_acc   = mac_sat;
        end else if (text_byte_i == CHAR_COMMA) begin
          next_state = ST_POPNUM;
        end else if (text_byte_i == CHAR_QUOTE) begin
          next_state = ST_DONE;
          accepted   = 1'b1;
        end
      end
      ST_DONE: begin
        next_state = ST_DONE;
      end
      default: begin
        next_state = ST_ERR;
      end
    endcase
  end

  // Resolve line end and pick the result
  always_comb begin
    state_o         = next_state;
    acc_o           = next_acc;
    res_o.valid     = 1'b0;
    res_o.kind      = KIND_NAME;
    res_o.name_char = '0;
    pop_ext         = '0;
    priority if (accepted) begin
      res_o.valid = 1'b1;
      res_o.kind  = KIND_ACCEPT;
      pop_ext     = ExtW'(accept_pop);
      if (line_end_i) begin
        state_o = ST_START;
        acc_o   = '0;
      end
    end else if (line_end_i) begin
      state_o     = ST_START;
      acc_o       = '0;
      res_o.valid = (next_state != ST_DONE);
      res_o.kind  = KIND_REJECT;
    end else begin
      // Pass a name byte through, otherwise stay silent
      res_o.valid     = name_out;
      res_o.kind      = KIND_NAME;
      res_o.name_char = name_out ? text_byte_i : 8'h00;
    end
  end

  assign population_o = pop_ext[POP_OUT_W-1:0];

endmodule : csvp_step

`default_nettype wire

FILE: rtl/quoted_csv_record_parser_top.sv
// ----------------------------------------------------------------------------
// quoted_csv_record_parser_top
// Byte-stream parser for rank,"name","population" CSV lines.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one text byte per
//   transaction, with line_end_i set on the last byte of each line.
//   Output channel (out_valid_o / out_ready_i) carries at most one result
//   per input byte: a name byte, an accept with the population, or a
//   reject for a line that ended before the record was complete.
// Path: a byte is held in the input register and its result is loaded
//   into the output register when the byte advances, which raises
//   out_valid_o; the result is taken on an edge with out_ready_i high.
// Throughput: one byte per cycle while results are taken, set by the
//   single parse step between the input register and the result register.
// Stall: while the result register holds an untaken result the input
//   register holds too; in_ready_o falls only when both are full.
// Reset: parser returns to start of line with a cleared accumulator,
//   both registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_csv_record_parser_top #(
  parameter int unsigned POP_BITS = 31
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        text_byte_i,
  input  logic                              line_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        result_kind_o,
  output logic [7:0]                        name_char_o,
  output logic [csvp_pkg::POP_OUT_W-1:0]    population_o
);
  import csvp_pkg::*;

  logic                   in_valid_q;
  logic [7:0]             byte_q;
  logic                   last_q;
  logic                   advance;

  parse_state_e           state_q, state_d;
  logic [POP_BITS-1:0]    acc_q, acc_d;
  step_res_t              step_res;
  logic [POP_OUT_W-1:0]   step_pop;

  logic                   out_valid_q;
  result_kind_e           kind_q;
  logic [7:0]             char_q;
  logic [POP_OUT_W-1:0]   pop_q;

  // Move the held byte forward when the result register can take it
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= text_byte_i;
      last_q <= line_end_i;
    end
  end

  // Parse step
  csvp_step #(
    .POP_BITS (POP_BITS)
  ) u_step (
    .state_i      (state_q),
    .acc_i        (acc_q),
    .text_byte_i  (byte_q),
    .line_end_i   (last_q),
    .state_o      (state_d),
    .acc_o        (acc_d),
    .res_o        (step_res),
    .population_o (step_pop)
  );

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      acc_q   <= '0;
    end else if (advance) begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  // Result register valid: drop on take, set on a new result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step_res.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance && step_res.valid) begin
      kind_q <= step_res.kind;
      char_q <= step_res.name_char;
      pop_q  <= step_pop;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign name_char_o   = char_q;
  assign population_o  = pop_q;

endmodule : quoted_csv_record_parser_top

`default_nettype wire
